FILE: rtl/iwe_pkg.sv
package iwe_pkg;

  localparam int unsigned MemWordsDefault = 1024;
  localparam int unsigned WordW = 40;
  localparam int unsigned HalfW = 20;
  localparam int unsigned AddrInW = 10;
  localparam int unsigned PcW = 10;

  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeRead  = 2'd1,
    ModeExec  = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatDone   = 2'd0,
    StatHalted = 2'd1,
    StatJump   = 2'd2,
    StatUnused = 2'd3
  } status_e;

  localparam logic [7:0] OpLoad  = 8'h01;
  localparam logic [7:0] OpAdd   = 8'h05;
  localparam logic [7:0] OpSub   = 8'h06;
  localparam logic [7:0] OpStor  = 8'h21;
  localparam logic [7:0] OpLsh   = 8'h14;
  localparam logic [7:0] OpMul   = 8'h0B;
  localparam logic [7:0] OpLdMq  = 8'h0A;
  localparam logic [7:0] OpLdMqM = 8'h09;
  localparam logic [7:0] OpJump  = 8'h0D;

  // Datapath operations selected by the controller.
  typedef enum logic [3:0] {
    DpNop,
    DpClear,      // clear one store entry during the pass after reset
    DpCapture,    // latch request fields
    DpMemWrite,   // write request data at request address
    DpMemRead,    // launch a read at request address
    DpFetch,      // launch a read at the program counter
    DpLatchWord,  // latch fetched instruction word
    DpOperand,    // launch operand read of current half
    DpExecute,    // apply current half with registered operand
    DpMulStep,    // one partial-product step of the multiplier
    DpMulFinish,  // sign-correct and commit the product
    DpLatchRead,  // latch read data for the result
    DpPcNext,     // advance PC by one
    DpPcJump      // PC takes the jump target
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       right_half;
    logic [1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    mode_e      mode;
    logic       word_valid;   // the addressed word was ever written
    logic [7:0] opcode;       // opcode of the selected half
    logic       clear_last;   // the clearing pass is at its last entry
  } dp_stat_t;

endpackage

FILE: rtl/iwe_datapath.sv
module iwe_datapath #(
  parameter int unsigned MemWords = iwe_pkg::MemWordsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  iwe_pkg::dp_cmd_t         cmd_i,
  output iwe_pkg::dp_stat_t        stat_o,
  input  logic [1:0]               mode_i,
  input  logic [9:0]               address_i,
  input  logic signed [39:0]       data_i,
  output logic signed [39:0]       read_data_o,
  output logic signed [39:0]       acc_value_o,
  output logic [39:0]              mq_value_o,
  output logic [9:0]               pc_value_o
);
  import iwe_pkg::*;

  localparam int unsigned IdxW = $clog2(MemWords);

  // Word reduction by reciprocal multiplication; exact for 12-bit addresses.
  localparam int unsigned RecipSh = 24;
  localparam logic [20:0] Recip = 21'(((1 << RecipSh) + MemWords - 1) / MemWords);
  localparam logic [12:0] MemW13 = 13'(MemWords);

  // The top bit of each entry marks a word that was written.
  logic [WordW:0] mem_q [MemWords];

  logic [WordW:0]   rdata_q;
  logic [IdxW-1:0]  clr_q;
  logic [1:0]       mode_q;
  logic [IdxW-1:0]  addr_q;
  logic [WordW-1:0] wdata_q;
  logic [WordW-1:0] word_q;
  logic [WordW-1:0] acc_q, mq_q, rd_q;
  logic [PcW-1:0]   pc_q;
  logic [IdxW-1:0]  target_q;

  // Multiplier: magnitudes, 20x20 partial products accumulated over four steps.
  logic [WordW-1:0]   ma_q, mb_q;
  logic               mneg_q;
  logic [2*WordW-1:0] prod_q;

  logic [HalfW-1:0] half;
  logic [IdxW-1:0]  opnd_idx;
  logic [IdxW-1:0]  pc_idx;
  logic [WordW-1:0] opnd;
  logic [19:0]      pa, pb;
  logic [39:0]      pp;
  logic [2*WordW-1:0] pp_sh, prod_neg;
  logic [WordW-1:0] mq_mag, op_mag;

  // Address and PC reduce modulo the memory depth.
  function automatic logic [IdxW-1:0] widx(input logic [11:0] a);
    logic [32:0] scaled;
    logic [7:0]  quot;
    logic [20:0] back;
    logic [11:0] rem;
    scaled = {21'd0, a} * {12'd0, Recip};
    quot   = scaled[RecipSh +: 8];
    back   = {13'd0, quot} * {8'd0, MemW13};
    rem    = a - back[11:0];
    return rem[IdxW-1:0];
  endfunction

  function automatic logic [WordW-1:0] mag(input logic [WordW-1:0] v);
    return v[WordW-1] ? (~v + 1'b1) : v;
  endfunction

  assign half     = cmd_i.right_half ? word_q[HalfW-1:0] : word_q[WordW-1:HalfW];
  assign opnd_idx = widx(half[11:0]);
  assign pc_idx   = widx({2'd0, pc_q});
  assign opnd     = rdata_q[WordW] ? rdata_q[WordW-1:0] : '0;
  assign mq_mag   = mag(mq_q);
  assign op_mag   = mag(opnd);

  assign pa = cmd_i.step[0] ? ma_q[39:20] : ma_q[19:0];
  assign pb = cmd_i.step[1] ? mb_q[39:20] : mb_q[19:0];
  assign pp = {20'd0, pa} * {20'd0, pb};
  assign pp_sh = {40'd0, pp} << (6'd20 * ({5'd0, cmd_i.step[0]} + {5'd0, cmd_i.step[1]}));
  assign prod_neg = ~prod_q + 1'b1;

  assign stat_o.mode       = mode_e'(mode_q);
  assign stat_o.word_valid = rdata_q[WordW];
  assign stat_o.opcode     = half[19:12];
  assign stat_o.clear_last = (clr_q == IdxW'(MemWords - 1));

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DpClear:    mem_q[clr_q] <= '0;
      DpMemWrite: mem_q[addr_q] <= {1'b1, wdata_q};
      DpExecute:  if (half[19:12] == OpStor) mem_q[opnd_idx] <= {1'b1, acc_q};
      default: ;
    endcase
    case (cmd_i.op)
      DpMemRead: rdata_q <= mem_q[addr_q];
      DpFetch:   rdata_q <= mem_q[pc_idx];
      DpOperand: rdata_q <= mem_q[opnd_idx];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      mode_q   <= '0;
      addr_q   <= '0;
      wdata_q  <= '0;
      word_q   <= '0;
      acc_q    <= '0;
      mq_q     <= '0;
      pc_q     <= '0;
      rd_q     <= '0;
      target_q <= '0;
      ma_q     <= '0;
      mb_q     <= '0;
      mneg_q   <= 1'b0;
      prod_q   <= '0;
    end else begin
      case (cmd_i.op)
        DpClear: clr_q <= clr_q + IdxW'(1);
        DpCapture: begin
          mode_q  <= mode_i;
          addr_q  <= widx({2'd0, address_i});
          wdata_q <= data_i;
          rd_q    <= '0;
        end
        DpLatchWord: word_q <= rdata_q[WordW-1:0];
        DpLatchRead: rd_q <= opnd;
        DpExecute: begin
          case (half[19:12])
            OpLoad:  acc_q <= opnd;
            OpAdd:   acc_q <= acc_q + opnd;
            OpSub:   acc_q <= acc_q - opnd;
            OpLsh:   acc_q <= {acc_q[WordW-2:0], 1'b0};
            OpLdMq:  acc_q <= mq_q;
            OpLdMqM: mq_q <= opnd;
            OpMul: begin
              ma_q   <= mq_mag;
              mb_q   <= op_mag;
              mneg_q <= mq_q[WordW-1] ^ opnd[WordW-1];
              prod_q <= '0;
            end
            OpJump:  target_q <= opnd_idx;
            default: ;
          endcase
        end
        DpMulStep: prod_q <= prod_q + pp_sh;
        DpMulFinish: begin
          {acc_q, mq_q} <= mneg_q ? prod_neg : prod_q;
        end
        DpPcNext: pc_q <= PcW'(widx({2'd0, pc_q} + 12'd1));
        DpPcJump: pc_q <= PcW'(target_q);
        default: ;
      endcase
    end
  end

  assign read_data_o = rd_q;
  assign acc_value_o = acc_q;
  assign mq_value_o  = mq_q;
  assign pc_value_o  = pc_q;
endmodule

FILE: rtl/iwe_controller.sv
module iwe_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [1:0]        status_o,
  output iwe_pkg::dp_cmd_t  cmd_o,
  input  iwe_pkg::dp_stat_t stat_i
);
  import iwe_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StDispatch, StReadWait, StFetchWait, StDecode,
    StOperand, StExec, StMul, StMulDone, StFinish, StOut
  } state_e;

  state_e     state_q;
  logic       right_q;
  logic [1:0] step_q;
  logic       jumped_q;
  logic [1:0] status_q;

  assign ready_o  = (state_q == StIdle);
  assign valid_o  = (state_q == StOut);
  assign status_o = status_q;

  always_comb begin
    cmd_o.op         = DpNop;
    cmd_o.right_half = right_q;
    cmd_o.step       = step_q;
    case (state_q)
      StClear:    cmd_o.op = DpClear;
      StIdle:     if (valid_i) cmd_o.op = DpCapture;
      StDispatch: begin
        case (stat_i.mode)
          ModeWrite: cmd_o.op = DpMemWrite;
          ModeRead:  cmd_o.op = DpMemRead;
          ModeExec:  cmd_o.op = DpFetch;
          default:   cmd_o.op = DpNop;
        endcase
      end
      StReadWait:  cmd_o.op = DpLatchRead;
      StFetchWait: if (stat_i.word_valid) cmd_o.op = DpLatchWord;
      StOperand:   cmd_o.op = DpOperand;
      StExec:      cmd_o.op = DpExecute;
      StMul:       cmd_o.op = DpMulStep;
      StMulDone:   cmd_o.op = DpMulFinish;
      StFinish:    cmd_o.op = jumped_q ? DpPcJump : DpPcNext;
      default:     cmd_o.op = DpNop;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      right_q  <= 1'b0;
      step_q   <= '0;
      jumped_q <= 1'b0;
      status_q <= StatDone;
    end else begin
      case (state_q)
        StClear: if (stat_i.clear_last) state_q <= StIdle;
        StIdle: if (valid_i) begin
          state_q  <= StDispatch;
          right_q  <= 1'b0;
          jumped_q <= 1'b0;
          status_q <= StatDone;
        end
        StDispatch: begin
          case (stat_i.mode)
            ModeRead: state_q <= StReadWait;
            ModeExec: state_q <= StFetchWait;
            default:  state_q <= StOut;
          endcase
        end
        StReadWait: state_q <= StOut;
        StFetchWait: begin
          if (stat_i.word_valid) state_q <= StDecode;
          else begin
            status_q <= StatHalted;
            state_q  <= StOut;
          end
        end
        StDecode:  state_q <= StOperand;
        StOperand: state_q <= StExec;
        StExec: begin
          step_q <= '0;
          if (stat_i.opcode == OpMul) state_q <= StMul;
          else if (stat_i.opcode == OpJump) begin
            jumped_q <= 1'b1;
            status_q <= StatJump;
            state_q  <= StFinish;
          end else if (!right_q) begin
            right_q <= 1'b1;
            state_q <= StOperand;
          end else state_q <= StFinish;
        end
        StMul: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) state_q <= StMulDone;
        end
        StMulDone: begin
          if (!right_q) begin
            right_q <= 1'b1;
            state_q <= StOperand;
          end else state_q <= StFinish;
        end
        StFinish: state_q <= StOut;
        StOut: if (ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: rtl/ias_word_executor_unit.sv
// IAS word executor. Each request writes a memory word (mode 0), reads one
// (mode 1), or executes the two instructions of the word at the program
// counter (mode 2); mode 3 only reports the registers. Exactly one result is
// returned per request, carrying the read data, AC, MQ, PC and a status code
// (done, halted on an empty word, or jump taken). Requests are handled one at
// a time. An execute fetches the word from the single-port word store, then
// makes one operand access per executed half; a MUL half uses the 40x40
// multiplier, which forms its product from four 20x20 partial products. Each
// store entry carries a written flag; after reset a clearing pass empties
// every word, and no request is accepted until it ends.
module ias_word_executor_unit #(
  parameter int unsigned MemWords = iwe_pkg::MemWordsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         address_i,
  input  logic signed [39:0] data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [39:0] read_data_o,
  output logic signed [39:0] acc_value_o,
  output logic [39:0]        mq_value_o,
  output logic [9:0]         pc_value_o,
  output logic [1:0]         status_o
);
  import iwe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  iwe_controller u_ctrl (
    .clk_i, .rst_ni, .valid_i, .ready_o, .valid_o, .ready_i, .status_o,
    .cmd_o(cmd), .stat_i(stat)
  );

  iwe_datapath #(.MemWords(MemWords)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .mode_i, .address_i, .data_i,
    .read_data_o, .acc_value_o, .mq_value_o, .pc_value_o
  );
endmodule

FILE: sim/tb.sv
module tb;
  import iwe_pkg::*;

  // One pending request as queued by the stimulus block. A pause entry is not
  // sent; it makes the driver wait until every expected result has come back.
  typedef struct {
    logic [1:0]  mode;
    logic [9:0]  addr;
    logic [39:0] data;
    bit          pause;
    bit          eager;
  } req_t;

  // One result of the block, field by field.
  typedef struct {
    logic [39:0] rd;
    logic [39:0] ac;
    logic [39:0] mq;
    logic [9:0]  pc;
    logic [1:0]  st;
  } res_t;

  localparam int GenBank = 0;
  localparam int ChkBank = 1;
  localparam int DrainWait = 40;

  logic clk_i, rst_ni;
  logic valid_i, ready_o, valid_o, ready_i;
  logic [1:0] mode_i;
  logic [9:0] address_i;
  logic [39:0] data_i;
  logic signed [39:0] read_data_o, acc_value_o;
  logic [39:0] mq_value_o;
  logic [9:0] pc_value_o;
  logic [1:0] status_o;

  ias_word_executor_unit dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .mode_i, .address_i, .data_i,
    .valid_o, .ready_i, .read_data_o, .acc_value_o, .mq_value_o, .pc_value_o,
    .status_o
  );

  // Two copies of the machine state. The stimulus block steps its own copy so
  // that it never builds an execute whose operand word was never written. The
  // checking copy is stepped on every accepted request.
  logic [39:0] word_mem [2][MemWordsDefault];
  bit          word_set [2][MemWordsDefault];
  logic [9:0]  pc_reg [2];
  logic [39:0] ac_reg [2];
  logic [39:0] mq_reg [2];

  req_t pending_reqs [$];
  res_t expected_results [$];
  int   errors = 0;
  int   n_accepted = 0;
  int   n_results = 0;
  int   n_exec = 0, n_jump = 0, n_halt = 0;
  bit   in_fire = 0;
  bit   stim_done = 0;
  bit   hold_started = 0;
  int   hold_cnt = 0;

  function automatic logic [19:0] instr(logic [7:0] op, logic [11:0] a);
    return {op, a};
  endfunction

  function automatic logic [39:0] mem_rd(int b, logic [11:0] a);
    int i;
    i = a % MemWordsDefault;
    return word_set[b][i] ? word_mem[b][i] : 40'd0;
  endfunction

  // Applies one instruction half to bank b; returns 1 when it jumps.
  function automatic bit exec_half(int b, logic [19:0] ins, output logic [9:0] tgt);
    logic [7:0] op;
    logic [11:0] a;
    logic signed [79:0] prod;
    op = ins[19:12];
    a = ins[11:0];
    tgt = 10'(a % MemWordsDefault);
    case (op)
      OpLoad:  ac_reg[b] = mem_rd(b, a);
      OpAdd:   ac_reg[b] = ac_reg[b] + mem_rd(b, a);
      OpSub:   ac_reg[b] = ac_reg[b] - mem_rd(b, a);
      OpStor: begin
        word_mem[b][a % MemWordsDefault] = ac_reg[b];
        word_set[b][a % MemWordsDefault] = 1;
      end
      OpLsh:   ac_reg[b] = {ac_reg[b][38:0], 1'b0};
      OpMul: begin
        prod = $signed(mq_reg[b]) * $signed(mem_rd(b, a));
        ac_reg[b] = prod[79:40];
        mq_reg[b] = prod[39:0];
      end
      OpLdMq:  ac_reg[b] = mq_reg[b];
      OpLdMqM: mq_reg[b] = mem_rd(b, a);
      OpJump:  return 1;
      default: ;
    endcase
    return 0;
  endfunction

  function automatic res_t ias_step(int b, req_t r);
    res_t o;
    int i;
    logic [39:0] w;
    logic [9:0] tgt;
    bit jumped;
    o.rd = 0;
    o.st = StatDone;
    i = r.addr % MemWordsDefault;
    if (r.mode == ModeWrite) begin
      word_mem[b][i] = r.data;
      word_set[b][i] = 1;
    end else if (r.mode == ModeRead) begin
      o.rd = mem_rd(b, 12'(r.addr));
    end else if (r.mode == ModeExec) begin
      if (!word_set[b][pc_reg[b]]) begin
        o.st = StatHalted;
      end else begin
        w = word_mem[b][pc_reg[b]];
        jumped = exec_half(b, w[39:20], tgt);
        if (!jumped) jumped = exec_half(b, w[19:0], tgt);
        if (jumped) begin
          pc_reg[b] = tgt;
          o.st = StatJump;
        end else begin
          pc_reg[b] = 10'((pc_reg[b] + 1) % MemWordsDefault);
        end
      end
    end
    o.ac = ac_reg[b];
    o.mq = mq_reg[b];
    o.pc = pc_reg[b];
    return o;
  endfunction

  function automatic bit reads_mem(logic [7:0] op);
    return op == OpLoad || op == OpAdd || op == OpSub || op == OpMul || op == OpLdMqM;
  endfunction

  task automatic push_req(logic [1:0] m, logic [9:0] a, logic [39:0] d, bit eager);
    req_t r;
    res_t unused;
    r.mode = m;
    r.addr = a;
    r.data = d;
    r.pause = 0;
    r.eager = eager;
    unused = ias_step(GenBank, r);
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // Queues an execute, first writing any operand word the instructions at the
  // program counter would read but that was never written.
  task automatic push_exec(bit eager);
    logic [39:0] w;
    logic [19:0] h;
    bit again;
    do begin
      again = 0;
      if (word_set[GenBank][pc_reg[GenBank]]) begin
        w = word_mem[GenBank][pc_reg[GenBank]];
        for (int k = 0; k < 2 && !again; k++) begin
          h = (k == 0) ? w[39:20] : w[19:0];
          if (k == 1 && w[39:32] == OpJump) break;
          if (reads_mem(h[19:12]) && !word_set[GenBank][h[11:0] % MemWordsDefault]) begin
            push_req(ModeWrite, 10'(h[11:0] % MemWordsDefault), rand40(), eager);
            again = 1;
          end
        end
      end
    end while (again);
    push_req(ModeExec, 10'($urandom), rand40(), eager);
  endtask

  task automatic push_pause();
    req_t r;
    r.mode = ModeNone;
    r.addr = 0;
    r.data = 0;
    r.pause = 1;
    r.eager = 0;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic logic [19:0] rand_instr();
    logic [7:0] ops [9];
    logic [7:0] op;
    logic [11:0] a;
    ops = '{OpLoad, OpAdd, OpSub, OpStor, OpLsh, OpMul, OpLdMq, OpLdMqM, OpJump};
    op = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ops[$urandom_range(0, 8)];
    // Mostly a small operand pool; the two top address bits exercise wrapping.
    a = {2'($urandom), ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63))};
    return instr(op, a);
  endfunction

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus. The generator bank starts from the reset state.
  initial begin
    int r;
    logic [9:0] a;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < MemWordsDefault; i++) begin
        word_mem[b][i] = 0;
        word_set[b][i] = 0;
      end
      pc_reg[b] = 0;
      ac_reg[b] = 0;
      mq_reg[b] = 0;
    end

    // Directed part: every opcode, operand extremes, both jump halves,
    // address and program counter wrap, empty reads and halts, mode three.
    push_req(ModeExec, 0, 0, 0);
    push_req(ModeWrite, 100, 40'h80_0000_0000, 0);
    push_req(ModeWrite, 101, 40'h7F_FFFF_FFFF, 0);
    push_req(ModeWrite, 0, {instr(OpLoad, 12'd100), instr(OpAdd, 12'hC65)}, 0);
    push_req(ModeWrite, 1, {instr(OpSub, 12'd100), instr(OpStor, 12'd102)}, 0);
    push_req(ModeWrite, 2, {instr(OpLsh, 12'd0), instr(OpLdMqM, 12'd101)}, 0);
    push_req(ModeWrite, 3, {instr(OpMul, 12'd100), instr(OpLdMq, 12'd0)}, 0);
    push_req(ModeWrite, 4, {instr(OpJump, 12'h806), instr(OpLoad, 12'd100)}, 0);
    push_req(ModeWrite, 6, {instr(8'hFF, 12'd0), instr(OpJump, 12'h3FF)}, 0);
    push_req(ModeWrite, 1023, {instr(OpLdMqM, 12'd100), instr(OpMul, 12'd100)}, 0);
    for (int i = 0; i < 8; i++) push_exec(0);
    push_req(ModeRead, 102, 0, 0);
    push_req(ModeRead, 500, 0, 0);
    push_req(ModeRead, 10'h3FF, 0, 0);
    push_req(ModeNone, 10'h3FF, 40'hFF_FFFF_FFFF, 0);
    push_req(ModeWrite, 5, {instr(OpJump, 12'd600), instr(OpJump, 12'd0)}, 0);
    push_req(ModeWrite, 0, {instr(OpJump, 12'd5), instr(8'h00, 12'd0)}, 0);
    push_exec(0);
    push_exec(0);
    push_exec(0);
    push_pause();

    // Random part: mostly program words and executes over a small region.
    for (int n = 0; n < 600; n++) begin
      bit eager;
      eager = (n >= 300 && n < 400);
      if (n == 450) push_pause();
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if (!word_set[GenBank][pc_reg[GenBank]] && $urandom_range(0, 1))
          push_req(ModeWrite, pc_reg[GenBank], {rand_instr(), rand_instr()}, eager);
        push_exec(eager);
      end else if (r < 60) begin
        push_req(ModeWrite, 10'($urandom_range(0, 63)), {rand_instr(), rand_instr()}, eager);
      end else if (r < 68) begin
        push_req(ModeWrite, 10'($urandom), rand40(), eager);
      end else if (r < 83) begin
        a = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 63));
        push_req(ModeRead, a, rand40(), eager);
      end else if (r < 88) begin
        push_req(ModeNone, 10'($urandom), rand40(), eager);
      end else begin
        push_req(ModeWrite, 10'($urandom_range(0, 63)), rand40(), eager);
      end
    end
    stim_done = 1;

    wait (pending_reqs.size() == 0 && !valid_i);
    wait (expected_results.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    $display("Covered %0d requests, %0d results: %0d executes, %0d jumps, %0d halts.",
             n_accepted, n_results, n_exec, n_jump, n_halt);
    $display("Stimulus included a long output stall and a full drain pause.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: changes inputs at the falling edge. A new request is offered only
  // once the previous one was accepted at the last rising edge.
  initial begin
    valid_i = 0;
    mode_i = 0;
    address_i = 0;
    data_i = 0;
  end

  int pause_cnt = -1;

  always @(negedge clk_i) begin
    if (rst_ni && (!valid_i || in_fire)) begin
      if (pending_reqs.size() > 0 && pending_reqs[0].pause) begin
        // Hold off until everything sent has come back, then wait a little.
        valid_i <= 0;
        if (expected_results.size() == 0 && !in_fire) begin
          if (pause_cnt < 0) pause_cnt = DrainWait;
          else if (pause_cnt == 0) begin
            void'(pending_reqs.pop_front());
            pause_cnt = -1;
          end else pause_cnt--;
        end
      end else if (pending_reqs.size() > 0 &&
                   (pending_reqs[0].eager || $urandom_range(0, 99) >= 25)) begin
        req_t r;
        r = pending_reqs.pop_front();
        valid_i <= 1;
        mode_i <= r.mode;
        address_i <= r.addr;
        data_i <= r.data;
      end else begin
        valid_i <= 0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off while the sender keeps going,
  // and a stretch of constant readiness.
  initial ready_i = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ready_i <= 0;
    end else if (hold_cnt > 0) begin
      ready_i <= 0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_started && n_accepted >= 150) begin
      hold_started <= 1;
      hold_cnt <= 400;
      ready_i <= 0;
    end else if (n_accepted >= 320 && n_accepted < 440) begin
      ready_i <= 1;
    end else begin
      ready_i <= ($urandom_range(0, 99) >= 25);
    end
  end

  // Monitor and checker: samples at the rising edge. Results are compared
  // before the request accepted at the same edge is predicted.
  always @(posedge clk_i) begin
    res_t got, want;
    req_t r;
    if (rst_ni) begin
      in_fire <= valid_i && ready_o;
      if (valid_o && ready_i) begin
        got.rd = read_data_o;
        got.ac = acc_value_o;
        got.mq = mq_value_o;
        got.pc = pc_value_o;
        got.st = status_o;
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, got rd=%h ac=%h mq=%h pc=%h st=%0d",
                   $time, got.rd, got.ac, got.mq, got.pc, got.st);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.rd !== want.rd) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rd, got.rd);
            errors++;
          end
          if (got.ac !== want.ac) begin
            $display("%0t: acc_value expected %h actual %h", $time, want.ac, got.ac);
            errors++;
          end
          if (got.mq !== want.mq) begin
            $display("%0t: mq_value expected %h actual %h", $time, want.mq, got.mq);
            errors++;
          end
          if (got.pc !== want.pc) begin
            $display("%0t: pc_value expected %h actual %h", $time, want.pc, got.pc);
            errors++;
          end
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            errors++;
          end
        end
      end
      if (valid_i && ready_o) begin
        r.mode = mode_i;
        r.addr = address_i;
        r.data = data_i;
        r.pause = 0;
        r.eager = 0;
        want = ias_step(ChkBank, r);
        expected_results = {expected_results, want};
        n_accepted <= n_accepted + 1;
        if (r.mode == ModeExec) n_exec <= n_exec + 1;
        if (want.st == StatJump) n_jump <= n_jump + 1;
        if (want.st == StatHalted) n_halt <= n_halt + 1;
      end
    end else begin
      in_fire <= 0;
    end
  end

endmodule
